// ===== sv/stsr_pkg.sv =====
// Shared widths, codes, state type and control bundles of the sorted table search unit.
`timescale 1ns / 1ps

package stsr_pkg;

	localparam int DEPTH_DEF = 1024;

	localparam int KIND_W    = 2;
	localparam int VAL_W     = 32;
	localparam int STAT_W    = 2;
	localparam int POS_W     = 10;
	localparam int CNT_OUT_W = 11;
	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 24;

	localparam logic [KIND_W-1:0] REQ_APPEND = 2'd0;
	localparam logic [KIND_W-1:0] REQ_FIND   = 2'd1;
	localparam logic [KIND_W-1:0] REQ_REMOVE = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
	localparam logic [STAT_W-1:0] STAT_MISS = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_APPEND,
		ST_SEARCH,
		ST_COMPARE,
		ST_SHIFT,
		ST_DONE
	} stsr_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch;       // take the incoming beat
		logic append;      // store at the end of the table, or flag full
		logic srch_issue;  // read the probe entry
		logic srch_lt;     // probe below key: move low bound up
		logic srch_gt;     // probe above key: move high bound down
		logic hit;         // record the probe index as the answer
		logic set_miss;    // record a miss
		logic shift_step;  // read the next entry of the shift-down
		logic shift_fin;   // shift-down done: one entry fewer
		logic load_out;    // move the answer into the output register
	} stsr_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [KIND_W-1:0] in_kind;   // kind on the input port
		logic [KIND_W-1:0] kind;      // kind of the request at work
		logic              srch_open; // search window not empty
		logic              cmp_eq;
		logic              cmp_lt;
		logic              shift_more;
		logic              out_free;
	} stsr_stat_t;

endpackage

// ===== sv/sorted_table_search_remove_unit.sv =====
// Top level of the sorted table search unit: append, binary search and remove on a value table.
`timescale 1ns / 1ps

// Channel  Direction  Beat contents (lowest bits first)
// s_*      in         tdata: value (32, signed); tuser: req_type (2)
// m_*      out        tdata: position (10), count_after (11), 3 zero bits; tuser: status (2)
//
// One request is worked on at a time. An append stores the value at the end of the table
// or flags full; a find does a binary search, one table read per probe (at most 11 probes
// for 1024 entries). A remove that hits then moves every entry above the removed slot down
// one at a time through the single read port of the table; a remove that misses ends as a
// find that misses. The next request is taken in the cycle after the result register is
// loaded, even while that result still waits; its own result then waits until the register
// is free. Reset clears the entry count and the handshake state; the table itself is not
// cleared, since only entries below the count are ever read.
module sorted_table_search_remove_unit #(
	parameter int DEPTH = stsr_pkg::DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [stsr_pkg::S_TDATA_W-1:0] s_tdata,   // value
	input  logic [stsr_pkg::KIND_W-1:0]    s_tuser,   // req_type
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [stsr_pkg::M_TDATA_W-1:0] m_tdata,   // position, count_after, zero pad
	output logic [stsr_pkg::STAT_W-1:0]    m_tuser    // status
);
	import stsr_pkg::*;

	// The controller only sequences; every value, bound and the table live in the datapath.
	stsr_cmd_t  cmd;
	stsr_stat_t st;

	stsr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	stsr_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cmd      (cmd),
		.st       (st)
	);

endmodule

// ===== sv/stsr_ctrl.sv =====
// Controller state machine of the sorted table search unit.
`timescale 1ns / 1ps

module stsr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  stsr_pkg::stsr_stat_t st,
	output stsr_pkg::stsr_cmd_t  cmd
);
	import stsr_pkg::*;

	stsr_state_t state_q;
	stsr_state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.latch = 1'b1;
					if (st.in_kind == REQ_APPEND) begin
						state_nx = ST_APPEND;
					end else if (st.in_kind == REQ_FIND || st.in_kind == REQ_REMOVE) begin
						state_nx = ST_SEARCH;
					end else begin
						state_nx = ST_DONE;
					end
				end
			end
			ST_APPEND: begin
				cmd.append = 1'b1;
				state_nx   = ST_DONE;
			end
			ST_SEARCH: begin
				if (st.srch_open) begin
					cmd.srch_issue = 1'b1;
					state_nx       = ST_COMPARE;
				end else begin
					cmd.set_miss = 1'b1;
					state_nx     = ST_DONE;
				end
			end
			ST_COMPARE: begin
				if (st.cmp_eq) begin
					cmd.hit  = 1'b1;
					state_nx = (st.kind == REQ_REMOVE) ? ST_SHIFT : ST_DONE;
				end else if (st.cmp_lt) begin
					cmd.srch_lt = 1'b1;
					state_nx    = ST_SEARCH;
				end else begin
					cmd.srch_gt = 1'b1;
					state_nx    = ST_SEARCH;
				end
			end
			ST_SHIFT: begin
				if (st.shift_more) begin
					cmd.shift_step = 1'b1;
				end else begin
					cmd.shift_fin = 1'b1;
					state_nx      = ST_DONE;
				end
			end
			ST_DONE: begin
				if (st.out_free) begin
					cmd.load_out = 1'b1;
					state_nx     = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== sv/stsr_dp.sv =====
// Datapath of the sorted table search unit: table memory, bounds, count and output register.
`timescale 1ns / 1ps

module stsr_dp #(
	parameter int DEPTH = stsr_pkg::DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [stsr_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic [stsr_pkg::KIND_W-1:0]    s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [stsr_pkg::M_TDATA_W-1:0] m_tdata,
	output logic [stsr_pkg::STAT_W-1:0]    m_tuser,
	input  stsr_pkg::stsr_cmd_t            cmd,
	output stsr_pkg::stsr_stat_t           st
);
	import stsr_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic signed [VAL_W-1:0] mem [DEPTH];

	logic [KIND_W-1:0]       kind_q;
	logic signed [VAL_W-1:0] value_q;
	logic [CW-1:0]           count_q;
	logic [CW-1:0]           lo_q;
	logic [CW-1:0]           hip1_q;   // high bound plus one
	logic [CW-1:0]           mid_q;
	logic [CW-1:0]           sp_q;     // slot being refilled by the shift-down
	logic [AW-1:0]           pend_addr_q;
	logic                    pend_q;
	logic signed [VAL_W-1:0] rdata_q;
	logic [STAT_W-1:0]       status_q;
	logic [AW-1:0]           pos_q;

	logic                    out_valid_q;
	logic [STAT_W-1:0]       out_status_q;
	logic [POS_W-1:0]        out_pos_q;
	logic [CNT_OUT_W-1:0]    out_cnt_q;

	logic [CW-1:0]           mid_w;
	logic [CW-1:0]           sp_nx;
	logic                    full;
	logic                    rd_en;
	logic [AW-1:0]           rd_addr;
	logic                    wr_en;
	logic [AW-1:0]           wr_addr;
	logic signed [VAL_W-1:0] wr_data;

	assign mid_w = lo_q + ((hip1_q - lo_q - CW'(1)) >> 1);
	assign sp_nx = sp_q + CW'(1);
	assign full  = (count_q == CW'(DEPTH));

	assign rd_en   = cmd.srch_issue | cmd.shift_step;
	assign rd_addr = cmd.srch_issue ? mid_w[AW-1:0] : sp_nx[AW-1:0];

	// Append writes at the end; the shift-down writes the entry read in the cycle before.
	assign wr_en   = (cmd.append & ~full) | pend_q;
	assign wr_addr = pend_q ? pend_addr_q : count_q[AW-1:0];
	assign wr_data = pend_q ? rdata_q : value_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			pend_q <= cmd.shift_step;
			if (cmd.append && !full) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.shift_fin) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			kind_q   <= s_tuser;
			value_q  <= s_tdata[VAL_W-1:0];
			lo_q     <= '0;
			hip1_q   <= count_q;
			status_q <= STAT_OK;
			pos_q    <= '0;
		end
		if (cmd.append) begin
			if (full) begin
				status_q <= STAT_FULL;
			end else begin
				pos_q <= count_q[AW-1:0];
			end
		end
		if (cmd.srch_issue) begin
			mid_q <= mid_w;
		end
		if (cmd.srch_lt) begin
			lo_q <= mid_q + CW'(1);
		end
		if (cmd.srch_gt) begin
			hip1_q <= mid_q;
		end
		if (cmd.set_miss) begin
			status_q <= STAT_MISS;
		end
		if (cmd.hit) begin
			pos_q <= mid_q[AW-1:0];
			sp_q  <= mid_q;
		end
		if (cmd.shift_step) begin
			pend_addr_q <= sp_q[AW-1:0];
			sp_q        <= sp_nx;
		end
		if (cmd.load_out) begin
			out_status_q <= status_q;
			out_pos_q    <= POS_W'(pos_q);
			out_cnt_q    <= CNT_OUT_W'(count_q);
		end
	end

	assign st.in_kind    = s_tuser;
	assign st.kind       = kind_q;
	assign st.srch_open  = (lo_q < hip1_q);
	assign st.cmp_eq     = (rdata_q == value_q);
	assign st.cmp_lt     = (rdata_q < value_q);
	assign st.shift_more = (sp_nx < count_q);
	assign st.out_free   = ~out_valid_q | m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = M_TDATA_W'({out_cnt_q, out_pos_q});

endmodule
